/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* hw/rtl/lfsa_pkg.sv */
// ---------------------------------------------------------------------------
// lfsa_pkg
// Shared constants and types of the lowest free slot allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 7;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // per-cycle command to the slot bank
  typedef struct packed {
    logic go;
    logic clear;
  } bank_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/lfsa_prio_enc.sv */
// ---------------------------------------------------------------------------
// lfsa_prio_enc
// Lowest-set-bit isolation and binary encode of the free slot vector.
// ---------------------------------------------------------------------------
`default_nettype none

module lfsa_prio_enc import lfsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = 6
) (
  input  wire logic [SLOTS-1:0] avail,
  output logic      [SLOTS-1:0] grant,
  output logic                  found,
  output logic      [IDX_W-1:0] index
);

  always_comb begin
    grant = avail & (~avail + SLOTS'(1));
    found = |avail;
    index = '0;
    for (int i = 0; i < SLOTS; i++) begin
      index = index | (grant[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lfsa_slot_bank.sv */
// ---------------------------------------------------------------------------
// lfsa_slot_bank
// Per-slot busy flags and free times, release compare and grant update.
// ---------------------------------------------------------------------------
`default_nettype none

module lfsa_slot_bank import lfsa_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bank_ctl_t            ctl,
  input  wire logic [TIME_BITS-1:0] arrive,
  input  wire logic [TIME_BITS-1:0] leave,
  input  wire logic [CFG_W-1:0]     active,
  input  wire logic [SLOTS-1:0]     grant,
  output logic      [SLOTS-1:0]     avail
);

  localparam int CNT_W = ($clog2(SLOTS + 1) > CFG_W) ? $clog2(SLOTS + 1) : CFG_W;

  logic [SLOTS-1:0]     busy_r;
  logic [SLOTS-1:0]     busy_nxt;
  logic [SLOTS-1:0]     held;
  logic [TIME_BITS-1:0] free_r [SLOTS];
  logic [CNT_W-1:0]     limit;

  assign limit = CNT_W'(active);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      held[i]  = busy_r[i] && !(free_r[i] < arrive);
      avail[i] = !held[i] && (CNT_W'(i) < limit);
    end
    busy_nxt = busy_r;
    if (ctl.go) begin
      busy_nxt = ctl.clear ? '0 : (held | grant);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (ctl.go && !ctl.clear && grant[i]) begin
        free_r[i] <= leave;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lowest_free_slot_allocator_top.sv */
// ---------------------------------------------------------------------------
// lowest_free_slot_allocator_top
// Path: an accepted item moves from the input register to the result
// register, where out_valid rises; a stalled output holds both in place.
// Throughput: 1 item per cycle unless the output stalls; the slot compare and
// priority encode sit between the input register and the result register.
// Reset: synchronous active low; all slots free, active_slots = 64.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lowest_free_slot_allocator_top import lfsa_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [TIME_BITS-1:0] in_arrive_time,
  input  wire logic [TIME_BITS-1:0] in_leave_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_granted,
  output logic      [IDX_W-1:0]     out_slot_index,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_clear_r;
  logic [TIME_BITS-1:0] s1_arrive_r;
  logic [TIME_BITS-1:0] s1_leave_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r;
  logic [IDX_W-1:0]     out_index_r;
  logic [CFG_W-1:0]     active_r;

  logic                 adv;
  logic                 in_acc;
  bank_ctl_t            ctl;
  logic [SLOTS-1:0]     avail;
  logic [SLOTS-1:0]     grant;
  logic                 found;
  logic [IDX_W-1:0]     index;

  assign cfg_ready = 1'b1;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign ctl.go    = s1_valid_r && adv;
  assign ctl.clear = (s1_clear_r == REQ_CLEAR);

  assign s1_valid_nxt  = in_acc ? 1'b1 : (ctl.go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = ctl.go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_clear_r  <= in_req_type;
      s1_arrive_r <= in_arrive_time;
      s1_leave_r  <= in_leave_time;
    end
    if (ctl.go) begin
      out_granted_r <= !ctl.clear && found;
      out_index_r   <= (!ctl.clear && found) ? index : '0;
    end
  end

  lfsa_slot_bank #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .arrive (s1_arrive_r),
    .leave  (s1_leave_r),
    .active (active_r),
    .grant  (grant),
    .avail  (avail)
  );

  lfsa_prio_enc #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_enc (
    .avail (avail),
    .grant (grant),
    .found (found),
    .index (index)
  );

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_slot_index = out_index_r;

  `ASSERT_CLK(a_grant_onehot, $onehot0(grant))
  `ASSERT_CLK(a_stall_needs_item, !s1_valid_r |-> !in_stall)
  `ASSERT_CLK(a_go_gives_result, ctl.go |=> out_valid_r)
  `ASSERT_CLK(a_refused_index_zero, (out_valid_r && !out_granted_r) |-> (out_index_r == '0))

endmodule

`default_nettype wire
